// File: hw/rtl/rpn_integer_evaluator_macros.svh
// assertion macros for the rpn evaluator
`ifndef RPN_INTEGER_EVALUATOR_MACROS_SVH
`define RPN_INTEGER_EVALUATOR_MACROS_SVH
// implication checked on every clock edge outside reset
`define RPN_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// implication whose consequent is checked in the following cycle
`define RPN_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/rpn_pkg.sv
// shared types and constants for the rpn evaluator
package rpn_pkg;
	localparam int StackDepthDef = 16;
	localparam int QueueDepth = 2;

	typedef enum logic [1:0] {
		OPN_PUSH = 2'd0,
		OPN_APPLY = 2'd1,
		OPN_END = 2'd2,
		OPN_NONE = 2'd3
	} opn_t;

	typedef enum logic [4:0] {
		OP_PLUS = 5'd0, OP_NEG = 5'd1, OP_NOT = 5'd2, OP_LNOT = 5'd3,
		OP_MUL = 5'd4, OP_DIV = 5'd5, OP_MOD = 5'd6, OP_ADD = 5'd7,
		OP_SUB = 5'd8, OP_SHL = 5'd9, OP_SHR = 5'd10, OP_GE = 5'd11,
		OP_GT = 5'd12, OP_LE = 5'd13, OP_LT = 5'd14, OP_EQ = 5'd15,
		OP_NE = 5'd16, OP_AND = 5'd17, OP_XOR = 5'd18, OP_OR = 5'd19,
		OP_LAND = 5'd20, OP_LOR = 5'd21, OP_ELSE = 5'd22, OP_IF = 5'd23
	} opc_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_FEW = 3'd1, ST_DIV0 = 3'd2, ST_MOD0 = 3'd3,
		ST_TERN = 3'd4, ST_COUNT = 3'd5, ST_OVER = 3'd6
	} status_t;

	// classified transaction handed from front to back
	typedef struct packed {
		opn_t opn;
		logic [4:0] opc;
		logic [1:0] need;
		logic [63:0] value;
	} cmd_t;

	function automatic logic [1:0] arg_count(input logic [4:0] opc);
		if (opc <= 5'd3) arg_count = 2'd1;
		else if (opc <= 5'd21) arg_count = 2'd2;
		else if (opc == 5'd22) arg_count = 2'd3;
		else arg_count = 2'd0;
	endfunction
endpackage

// File: hw/rtl/rpn_ram.sv
// generic single write port ram with registered read
module rpn_ram #(
	parameter int Width = 64,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/rpn_front.sv
// input stage and command queue
module rpn_front import rpn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] operation,
	input logic [63:0] value,
	input logic [4:0] operator_code,
	output logic cmd_valid,
	output cmd_t cmd,
	input logic cmd_take
);
	localparam int PtrW = $clog2(QueueDepth);
	cmd_t q_q [QueueDepth];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [PtrW:0] cnt_q;
	logic acc;
	cmd_t nc;

	always_comb begin
		nc.opn = opn_t'(operation);
		nc.opc = operator_code;
		nc.need = arg_count(operator_code);
		nc.value = value;
	end

	// operation 3 is dropped here
	assign full = (cnt_q == (PtrW+1)'(QueueDepth));
	assign acc = push && !full && (operation != OPN_NONE);
	assign cmd_valid = (cnt_q != '0);
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (acc) q_q[wp_q] <= nc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) wp_q <= wp_q + 1'b1;
			if (cmd_take) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(acc) - (PtrW+1)'(cmd_take);
		end
	end

	`include "rpn_integer_evaluator_macros.svh"
	`RPN_ASSERT_IMPL(a_take_valid, clk, arst_n, cmd_take, cmd_valid)
	`RPN_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= (PtrW+1)'(QueueDepth))
endmodule

// File: hw/rtl/rpn_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module rpn_divider import rpn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [63:0] divisor,
	output logic busy,
	output logic done,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);
	logic [63:0] quo_q, rem_q, dvs_q;
	logic [6:0] cnt_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};
	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (cnt_q == 7'd1);
			if (start) cnt_q <= 7'd64;
			else if (busy) cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

// File: hw/rtl/rpn_back.sv
// execution stage: value stack, alu and result register
module rpn_back import rpn_pkg::*; #(
	parameter int StackDepth = StackDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_take,
	output logic empty,
	input logic pop,
	output logic [63:0] final_value,
	output logic [2:0] status
);
	localparam int AW = $clog2(StackDepth);
	localparam int CW = $clog2(StackDepth + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD0 = 7'b0000010,
		S_RD1 = 7'b0000100,
		S_RD2 = 7'b0001000,
		S_DIV = 7'b0010000,
		S_EXE = 7'b0100000,
		S_MUL = 7'b1000000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [CW-1:0] cnt_q;
	status_t err_q;
	logic eif_q;
	logic [63:0] a0_q, a1_q, a2_q, bot_q;
	logic ovalid_q;
	logic [63:0] oval_q;
	logic [2:0] ost_q;
	logic [1:0] mstep_q;
	logic [63:0] prod_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0] wdata, rdata;
	logic dstart, dbusy, ddone;
	logic [63:0] dq, dr;
	logic [63:0] r;
	logic [CW-1:0] base;
	logic [31:0] mx, my;
	logic [63:0] mp;
	logic end_take;

	rpn_ram #(.Width(64), .Depth(StackDepth)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	// dividend is read straight from the ram in the cycle the divider starts
	rpn_divider u_div (
		.clk, .arst_n, .start(dstart), .dividend(rdata), .divisor(a0_q),
		.busy(dbusy), .done(ddone), .quotient(dq), .remainder(dr)
	);

	assign empty = !ovalid_q;
	assign final_value = oval_q;
	assign status = ost_q;
	assign base = cnt_q - CW'(cmd_q.need);

	// end waits for a free result slot
	assign cmd_take = (state_q == S_IDLE) && cmd_valid &&
		!(cmd.opn == OPN_END && ovalid_q && !pop);
	assign end_take = (state_q == S_IDLE) && cmd_take && (cmd.opn == OPN_END);

	always_comb begin
		raddr = AW'(cnt_q - CW'(1));
		case (state_q)
			S_IDLE: raddr = AW'(cnt_q - CW'(1));
			S_RD0: raddr = AW'(cnt_q - CW'(2));
			S_RD1: raddr = AW'(cnt_q - CW'(3));
			default: raddr = AW'(cnt_q - CW'(1));
		endcase
	end

	// one 32x32 partial product per cycle, low 64 bits kept
	always_comb begin
		case (mstep_q)
			2'd0: begin
				mx = a1_q[31:0];
				my = a0_q[31:0];
			end
			2'd1: begin
				mx = a1_q[31:0];
				my = a0_q[63:32];
			end
			default: begin
				mx = a1_q[63:32];
				my = a0_q[31:0];
			end
		endcase
		mp = 64'(mx) * 64'(my);
	end

	always_comb begin
		r = '0;
		case (opc_t'(cmd_q.opc))
			OP_NEG: r = 64'd0 - a0_q;
			OP_NOT: r = ~a0_q;
			OP_LNOT: r = {63'd0, a0_q == '0};
			OP_MUL: r = prod_q;
			OP_DIV: r = dq;
			OP_MOD: r = dr;
			OP_ADD: r = a1_q + a0_q;
			OP_SUB: r = a1_q - a0_q;
			OP_SHL: r = (a0_q[63:6] != '0) ? '0 : a1_q << a0_q[5:0];
			OP_SHR: r = (a0_q[63:6] != '0) ? '0 : a1_q >> a0_q[5:0];
			OP_GE: r = {63'd0, a1_q >= a0_q};
			OP_GT: r = {63'd0, a1_q > a0_q};
			OP_LE: r = {63'd0, a1_q <= a0_q};
			OP_LT: r = {63'd0, a1_q < a0_q};
			OP_EQ: r = {63'd0, a1_q == a0_q};
			OP_NE: r = {63'd0, a1_q != a0_q};
			OP_AND: r = a1_q & a0_q;
			OP_XOR: r = a1_q ^ a0_q;
			OP_OR: r = a1_q | a0_q;
			OP_LAND: r = {63'd0, (a1_q != '0) && (a0_q != '0)};
			OP_LOR: r = {63'd0, (a1_q != '0) || (a0_q != '0)};
			OP_ELSE: r = (a2_q != '0) ? a1_q : a0_q;
			default: r = '0;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = AW'(base);
		wdata = r;
		dstart = 1'b0;
		if (state_q == S_IDLE && cmd_take && cmd.opn == OPN_PUSH && err_q == ST_OK
			&& !eif_q && cnt_q != CW'(StackDepth)) begin
			we = 1'b1;
			waddr = AW'(cnt_q);
			wdata = cmd.value;
		end
		if (state_q == S_EXE) we = 1'b1;
		if (state_q == S_RD0 && cmd_q.need == 2'd1) we = 1'b0;
		if ((state_q == S_RD1 && cmd_q.need == 2'd2) || state_q == S_RD2)
			dstart = (opc_t'(cmd_q.opc) == OP_DIV || opc_t'(cmd_q.opc) == OP_MOD)
				&& a0_q != '0;
	end

	always_ff @(posedge clk) begin
		if (cmd_take) cmd_q <= cmd;
		case (state_q)
			S_RD0: a0_q <= rdata;
			S_RD1: a1_q <= rdata;
			S_RD2: a2_q <= rdata;
			default: ;
		endcase
		if (we && waddr == '0) bot_q <= wdata;
		if (state_q == S_MUL)
			prod_q <= (mstep_q == 2'd0) ? mp : prod_q + {mp[31:0], 32'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			err_q <= ST_OK;
			eif_q <= 1'b0;
			ovalid_q <= 1'b0;
			oval_q <= '0;
			ost_q <= '0;
			mstep_q <= '0;
		end else begin
			if (pop && ovalid_q && !end_take) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						if (cmd.opn == OPN_END) begin
							ovalid_q <= 1'b1;
							oval_q <= '0;
							if (err_q != ST_OK) ost_q <= err_q;
							else if (eif_q) ost_q <= ST_TERN;
							else if (cnt_q != CW'(1)) ost_q <= ST_COUNT;
							else begin
								ost_q <= ST_OK;
								oval_q <= bot_q;
							end
							cnt_q <= '0;
							err_q <= ST_OK;
							eif_q <= 1'b0;
						end else if (err_q != ST_OK) begin
						end else if (eif_q) begin
							eif_q <= 1'b0;
							if (!(cmd.opn == OPN_APPLY && opc_t'(cmd.opc) == OP_IF))
								err_q <= ST_TERN;
						end else if (cmd.opn == OPN_PUSH) begin
							if (cnt_q == CW'(StackDepth)) err_q <= ST_OVER;
							else cnt_q <= cnt_q + CW'(1);
						end else if (opc_t'(cmd.opc) == OP_IF) begin
							err_q <= ST_TERN;
						end else if (cmd.opc > 5'd23) begin
						end else if (cnt_q < CW'(cmd.need)) begin
							err_q <= ST_FEW;
						end else if (opc_t'(cmd.opc) != OP_PLUS) begin
							state_q <= S_RD0;
						end
					end
				end
				S_RD0: state_q <= (cmd_q.need == 2'd1) ? S_EXE : S_RD1;
				S_RD1: begin
					if (cmd_q.need == 2'd3) state_q <= S_RD2;
					else if (dstart) state_q <= S_DIV;
					else if ((opc_t'(cmd_q.opc) == OP_DIV || opc_t'(cmd_q.opc) == OP_MOD)
						&& a0_q == '0) begin
						err_q <= (opc_t'(cmd_q.opc) == OP_DIV) ? ST_DIV0 : ST_MOD0;
						state_q <= S_IDLE;
					end else if (opc_t'(cmd_q.opc) == OP_MUL) begin
						mstep_q <= '0;
						state_q <= S_MUL;
					end else state_q <= S_EXE;
				end
				S_RD2: state_q <= S_EXE;
				S_DIV: if (ddone) state_q <= S_EXE;
				S_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd2) state_q <= S_EXE;
				end
				S_EXE: begin
					cnt_q <= base + CW'(1);
					if (opc_t'(cmd_q.opc) == OP_ELSE) eif_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "rpn_integer_evaluator_macros.svh"
	`RPN_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(StackDepth))
	`RPN_ASSERT_IMPL(a_take_idle, clk, arst_n, cmd_take, state_q == S_IDLE)
	`RPN_ASSERT_NEXT(a_div_busy, clk, arst_n, dstart, state_q == S_DIV && dbusy)
	`RPN_ASSERT_IMPL(a_state_hot, clk, arst_n, 1'b1, $onehot(state_q))
endmodule

// File: hw/rtl/rpn_integer_evaluator.sv
// top level of the rpn integer evaluator
// Channels: input queue (push/full) takes operation, value and operator_code;
// result queue (empty/pop) shows final_value and status.
// Push and operator transactions give no result; an end transaction gives one
// result with the status code and, when status is ok, the single stack value.
// An input transaction other than operation 3 enters a two-entry command
// queue in its cycle; the execution side takes one command at a time.
// Push, end and unary plus are handled in the idle state; other operators read
// their arguments from the stack ram one per cycle, then write back the result.
// Multiply also steps through its partial products in the S_MUL state.
// Divide and modulo also wait in the S_DIV state for the bit-serial divider.
// The result stays on the ports until popped; while it waits, further pushes
// and operators still run, and a following end waits for the slot.
// Reset empties both queues and clears the stack count, error and pending if.
// The stack ram holds no reset; only entries below the count are used.
module rpn_integer_evaluator import rpn_pkg::*; #(
	parameter int StackDepth = StackDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] operation,
	input logic [63:0] value,
	input logic [4:0] operator_code,
	output logic empty,
	input logic pop,
	output logic [63:0] final_value,
	output logic [2:0] status
);
	logic cmd_valid, cmd_take;
	cmd_t cmd;

	rpn_front u_front (
		.clk, .arst_n, .push, .full, .operation, .value, .operator_code,
		.cmd_valid, .cmd, .cmd_take
	);

	rpn_back #(.StackDepth(StackDepth)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .empty, .pop,
		.final_value, .status
	);
endmodule

// File: verif/rpn_integer_evaluator_checker.sv
// checker for the rpn evaluator: predicts results and compares them
module rpn_integer_evaluator_checker import rpn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic [1:0] operation,
	input logic [63:0] value,
	input logic [4:0] operator_code,
	input logic empty,
	input logic pop,
	input logic [63:0] final_value,
	input logic [2:0] status,
	output int fail_count,
	output int pending_count
);
	typedef struct packed {
		logic [63:0] final_value;
		status_t status;
	} outcome_t;

	logic [63:0] stk [StackDepthDef];
	int depth;
	status_t sticky;
	bit if_due;
	outcome_t outcomes [$];

	function automatic void flag(input status_t code);
		if (sticky == ST_OK)
			sticky = code;
	endfunction

	task automatic evaluate(input opc_t opc);
		int need;
		logic [63:0] a0, a1, a2, r;
		need = (opc <= OP_LNOT) ? 1 : (opc <= OP_LOR) ? 2 : (opc == OP_ELSE) ? 3 : 0;
		a0 = 0;
		a1 = 0;
		a2 = 0;
		r = 0;
		if (opc == OP_IF) begin
			flag(ST_TERN);
			return;
		end
		if (opc > OP_IF)
			return;
		if (depth < need) begin
			flag(ST_FEW);
			return;
		end
		if (opc == OP_PLUS)
			return;
		a0 = stk[depth - 1];
		if (need >= 2) a1 = stk[depth - 2];
		if (need >= 3) a2 = stk[depth - 3];
		if (opc == OP_DIV && a0 == 0) begin
			flag(ST_DIV0);
			return;
		end
		if (opc == OP_MOD && a0 == 0) begin
			flag(ST_MOD0);
			return;
		end
		case (opc)
			OP_NEG: r = -a0;
			OP_NOT: r = ~a0;
			OP_LNOT: r = 64'(a0 == 0);
			OP_MUL: r = a1 * a0;
			OP_DIV: r = a1 / a0;
			OP_MOD: r = a1 % a0;
			OP_ADD: r = a1 + a0;
			OP_SUB: r = a1 - a0;
			OP_SHL: r = (a0 >= 64) ? 64'd0 : a1 << a0[5:0];
			OP_SHR: r = (a0 >= 64) ? 64'd0 : a1 >> a0[5:0];
			OP_GE: r = 64'(a1 >= a0);
			OP_GT: r = 64'(a1 > a0);
			OP_LE: r = 64'(a1 <= a0);
			OP_LT: r = 64'(a1 < a0);
			OP_EQ: r = 64'(a1 == a0);
			OP_NE: r = 64'(a1 != a0);
			OP_AND: r = a1 & a0;
			OP_XOR: r = a1 ^ a0;
			OP_OR: r = a1 | a0;
			OP_LAND: r = 64'(a1 != 0 && a0 != 0);
			OP_LOR: r = 64'(a1 != 0 || a0 != 0);
			default: begin
				r = (a2 != 0) ? a1 : a0;
				if_due = 1;
			end
		endcase
		depth -= need;
		stk[depth] = r;
		depth++;
	endtask

	task automatic absorb(input opn_t opn, input logic [63:0] v, input opc_t opc);
		outcome_t o;
		if (opn == OPN_NONE)
			return;
		if (opn == OPN_END) begin
			o.final_value = 0;
			if (sticky != ST_OK) o.status = sticky;
			else if (if_due) o.status = ST_TERN;
			else if (depth != 1) o.status = ST_COUNT;
			else begin
				o.status = ST_OK;
				o.final_value = stk[0];
			end
			outcomes.insert(outcomes.size(), o);
			depth = 0;
			sticky = ST_OK;
			if_due = 0;
			return;
		end
		if (sticky != ST_OK)
			return;
		if (if_due) begin
			if_due = 0;
			if (!(opn == OPN_APPLY && opc == OP_IF))
				flag(ST_TERN);
			return;
		end
		if (opn == OPN_PUSH) begin
			if (depth >= StackDepthDef)
				flag(ST_OVER);
			else begin
				stk[depth] = v;
				depth++;
			end
		end else
			evaluate(opc);
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			depth = 0;
			sticky = ST_OK;
			if_due = 0;
			outcomes.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (!empty && pop) begin
				if (outcomes.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					want = outcomes.pop_front();
					if (final_value !== want.final_value) begin
						$error("final_value expected %h actual %h", want.final_value, final_value);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, status);
						fail_count++;
					end
				end
			end
			if (push && !full)
				absorb(opn_t'(operation), value, opc_t'(operator_code));
			pending_count = outcomes.size();
		end
	end
endmodule

// File: verif/rpn_integer_evaluator_tb.sv
// testbench top for the rpn evaluator: stimulus, watchdog and verdict
module rpn_integer_evaluator_tb import rpn_pkg::*;;
	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic [1:0] operation = OPN_NONE;
	logic [63:0] value = 0;
	logic [4:0] operator_code = 0;
	logic pop = 0;
	logic full, empty;
	logic [63:0] final_value;
	logic [2:0] status;
	int fail_count, pending_count;
	int idle_cycles = 0;
	int sent = 0;
	bit calm = 0;
	bit sending = 1;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	rpn_integer_evaluator DUT (.*);
	rpn_integer_evaluator_checker u_checker (.*);

	// receiver stalls at random except in the calm stretch
	always @(posedge clk)
		pop <= calm || $urandom_range(99) >= 20;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send(input opn_t opn, input logic [63:0] v, input logic [4:0] opc);
		while (!calm && $urandom_range(99) < 20) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		operation <= opn;
		value <= v;
		operator_code <= opc;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(5))
			0: return 0;
			1: return 64'hFFFF_FFFF_FFFF_FFFF;
			2: return 64'($urandom_range(70));
			3: return 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic binary(input opc_t opc, input logic [63:0] a, input logic [63:0] b);
		send(OPN_PUSH, a, 0);
		send(OPN_PUSH, b, 0);
		send(OPN_APPLY, 0, opc);
		send(OPN_END, 0, 0);
	endtask

	task automatic random_expr();
		int d, len;
		len = $urandom_range(12, 1);
		d = 0;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0) begin
				send(opn_t'($urandom_range(3)), rand_word(), 5'($urandom));
			end else if (d < 3 || ($urandom_range(1) && d < 17)) begin
				send(OPN_PUSH, rand_word(), 0);
				d++;
			end else if ($urandom_range(7) == 0) begin
				send(OPN_APPLY, 0, OP_ELSE);
				if ($urandom_range(5) != 0)
					send(OPN_APPLY, 0, OP_IF);
				d -= 2;
			end else begin
				send(OPN_APPLY, 0, 5'($urandom_range(21)));
				d--;
			end
		end
		send(OPN_END, 0, 0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: every operator, ternary, errors, edges
		binary(OP_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		binary(OP_MOD, 7, 0);
		binary(OP_SHL, 1, 64);
		for (int k = 0; k <= 31; k++)
			binary(opc_t'(k), 64'hFFFF_FFFF_FFFF_FFFF, 3);
		send(OPN_PUSH, 5, 0);
		send(OPN_APPLY, 0, OP_PLUS);
		send(OPN_END, 0, 0);
		send(OPN_APPLY, 0, OP_ADD);
		send(OPN_END, 0, 0);
		send(OPN_PUSH, 1, 0);
		send(OPN_PUSH, 2, 0);
		send(OPN_PUSH, 3, 0);
		send(OPN_APPLY, 0, OP_ELSE);
		send(OPN_APPLY, 0, OP_IF);
		send(OPN_END, 0, 0);
		send(OPN_PUSH, 0, 0);
		send(OPN_PUSH, 2, 0);
		send(OPN_PUSH, 3, 0);
		send(OPN_APPLY, 0, OP_ELSE);
		send(OPN_END, 0, 0);
		send(OPN_APPLY, 0, OP_IF);
		send(OPN_NONE, 0, 0);
		send(OPN_END, 0, 0);
		for (int k = 0; k < 17; k++)
			send(OPN_PUSH, 64'(k), 0);
		send(OPN_END, 0, 0);
		send(OPN_END, 0, 0);
		// random expressions, with a calm stretch in the middle
		while (sent < 450) begin
			calm = (sent > 200 && sent < 340);
			random_expr();
		end
		calm = 0;
		push <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_ram.sv
hw/rtl/rpn_front.sv
hw/rtl/rpn_divider.sv
hw/rtl/rpn_back.sv
hw/rtl/rpn_integer_evaluator.sv
verif/rpn_integer_evaluator_checker.sv
verif/rpn_integer_evaluator_tb.sv
